@@ rtl/owtf_pkg.sv @@
// Shared types and constants for the one-wire temperature fan level controller.
`timescale 1ns / 1ps
package owtf_pkg;

   // Field widths
   localparam int TEMP_W  = 16;
   localparam int LEVEL_W = 3;
   localparam int DAC_W   = 8;
   localparam int CNT_W   = 24;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 24;

   // Level mapping
   localparam int THRESHOLD_RAW   = 432;
   localparam int MAX_LEVEL       = 5;
   localparam int LEVEL_STEP_CODE = 36;

   // One-wire commands
   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_PAD = 8'hBE;

   // Register indexes
   localparam logic [CSR_AW-1:0] CSR_RESET_PRE   = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_RESET_LOW   = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_PRES_DELAY  = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_PRES_POST   = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_WRITE_HOLD  = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_WRITE_REC   = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_READ_REC    = 3'd6;
   localparam logic [CSR_AW-1:0] CSR_CONVERSION  = 3'd7;

   // Timing registers as seen by the sequencer
   typedef struct packed {
      logic [15:0]      reset_pre_ticks;
      logic [15:0]      reset_low_ticks;
      logic [15:0]      presence_delay_ticks;
      logic [15:0]      presence_post_ticks;
      logic [15:0]      write_hold_ticks;
      logic [15:0]      write_recovery_ticks;
      logic [15:0]      read_recovery_ticks;
      logic [CNT_W-1:0] conversion_ticks;
   } cfg_type;

   // One tick's result from the sequencer
   typedef struct packed {
      logic               done_res;
      logic               busy_res;
      logic [TEMP_W-1:0]  temperature_raw;
      logic [LEVEL_W-1:0] fan_level;
      logic [DAC_W-1:0]   dac_code;
      logic               line_drive_low;
   } res_type;

endpackage

@@ rtl/onewire_temp_fan_level_controller.sv @@
// Top level: one-wire temperature master with fan level output.
//
//   channel  direction  per request                 ports
//   req      in         one bus tick (level, start) req_tvalid/req_tready/req_tdata
//   rsp      out        one result per tick         rsp_tvalid/rsp_tready/rsp_tdata
//   csr      in         timing register write       csr_we/csr_addr/csr_wdata
//
// A request is taken every cycle while the
// single output register is empty or being drained in that cycle.
// The sequencer state advances only on an accepted request, so stalls on
// either side only pause the bus timing. Synchronous reset restores the
// timing registers to their defaults and the sequencer to idle.
`timescale 1ns / 1ps
module onewire_temp_fan_level_controller (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,  // [0] line_level, [1] start_request
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [0] line_drive_low, [8:1] dac_code, [11:9] fan_level,
   // [27:12] temperature_raw, [28] busy_res, [29] done_res
   output logic [31:0]                  rsp_tdata,
   input  logic                         csr_we,
   input  logic [owtf_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [owtf_pkg::CSR_DW-1:0]  csr_wdata
);

   owtf_pkg::cfg_type cfg;
   owtf_pkg::res_type res;

   logic        accept;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   owtf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   owtf_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .advance       (accept),
      .line_level    (req_tdata[0]),
      .start_request (req_tdata[1]),
      .cfg           (cfg),
      .res           (res)
   );

   // Output register handshake
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = accept ? {2'b00, res} : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/owtf_csr.sv @@
// Timing register file, written through the plain write port.
`timescale 1ns / 1ps
module owtf_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [owtf_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [owtf_pkg::CSR_DW-1:0]   csr_wdata,
   output owtf_pkg::cfg_type             cfg
);

   owtf_pkg::cfg_type cfg_ff;
   owtf_pkg::cfg_type cfg_in;

   // Address decode, values masked to register width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            owtf_pkg::CSR_RESET_PRE:  cfg_in.reset_pre_ticks      = csr_wdata[15:0];
            owtf_pkg::CSR_RESET_LOW:  cfg_in.reset_low_ticks      = csr_wdata[15:0];
            owtf_pkg::CSR_PRES_DELAY: cfg_in.presence_delay_ticks = csr_wdata[15:0];
            owtf_pkg::CSR_PRES_POST:  cfg_in.presence_post_ticks  = csr_wdata[15:0];
            owtf_pkg::CSR_WRITE_HOLD: cfg_in.write_hold_ticks     = csr_wdata[15:0];
            owtf_pkg::CSR_WRITE_REC:  cfg_in.write_recovery_ticks = csr_wdata[15:0];
            owtf_pkg::CSR_READ_REC:   cfg_in.read_recovery_ticks  = csr_wdata[15:0];
            owtf_pkg::CSR_CONVERSION: cfg_in.conversion_ticks     = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_pre_ticks      <= 16'd8;
         cfg_ff.reset_low_ticks      <= 16'd80;
         cfg_ff.presence_delay_ticks <= 16'd14;
         cfg_ff.presence_post_ticks  <= 16'd20;
         cfg_ff.write_hold_ticks     <= 16'd10;
         cfg_ff.write_recovery_ticks <= 16'd5;
         cfg_ff.read_recovery_ticks  <= 16'd8;
         cfg_ff.conversion_ticks     <= 24'd150000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/owtf_level.sv @@
// Maps a raw temperature to a fan level and its DAC code.
`timescale 1ns / 1ps
module owtf_level (
   input  logic [owtf_pkg::TEMP_W-1:0]  temp,
   output logic [owtf_pkg::LEVEL_W-1:0] level,
   output logic [owtf_pkg::DAC_W-1:0]   dac
);

   localparam logic signed [owtf_pkg::TEMP_W:0] THRESH =
      (owtf_pkg::TEMP_W+1)'(owtf_pkg::THRESHOLD_RAW);
   localparam int STEPS_W = owtf_pkg::TEMP_W + 1 - 4;
   localparam int CODE_W  = owtf_pkg::LEVEL_W + 6;

   logic signed [owtf_pkg::TEMP_W:0] raw;
   logic signed [owtf_pkg::TEMP_W:0] diff;
   logic [STEPS_W-1:0]               steps;
   logic [CODE_W-1:0]                code;

   // Whole degrees above threshold, saturated
   always_comb begin
      raw   = $signed({temp[owtf_pkg::TEMP_W-1], temp});
      diff  = raw - THRESH;
      steps = diff[owtf_pkg::TEMP_W:4];
      if (raw <= THRESH) begin
         level = '0;
      end else if (steps > STEPS_W'(owtf_pkg::MAX_LEVEL)) begin
         level = owtf_pkg::LEVEL_W'(owtf_pkg::MAX_LEVEL);
      end else begin
         level = steps[owtf_pkg::LEVEL_W-1:0];
      end
      code = CODE_W'(level) * CODE_W'(owtf_pkg::LEVEL_STEP_CODE);
      if (code > CODE_W'(255)) begin
         dac = '1;
      end else begin
         dac = code[owtf_pkg::DAC_W-1:0];
      end
   end

endmodule

@@ rtl/owtf_seq.sv @@
// One-wire bus sequencer: reset, commands, conversion wait, scratchpad read, level apply.
`timescale 1ns / 1ps
module owtf_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              line_level,
   input  logic              start_request,
   input  owtf_pkg::cfg_type cfg,
   output owtf_pkg::res_type res
);

   // Phase codes
   localparam logic [3:0] PH_IDLE       = 4'd0;
   localparam logic [3:0] PH_RST_PRE    = 4'd1;
   localparam logic [3:0] PH_RST_LOW    = 4'd2;
   localparam logic [3:0] PH_PRES_DELAY = 4'd3;
   localparam logic [3:0] PH_PRES_LOW   = 4'd4;
   localparam logic [3:0] PH_PRES_HIGH  = 4'd5;
   localparam logic [3:0] PH_PRES_POST  = 4'd6;
   localparam logic [3:0] PH_WR_LOW     = 4'd7;
   localparam logic [3:0] PH_WR_HOLD    = 4'd8;
   localparam logic [3:0] PH_WR_REC     = 4'd9;
   localparam logic [3:0] PH_CONV       = 4'd10;
   localparam logic [3:0] PH_RD_LOW     = 4'd11;
   localparam logic [3:0] PH_RD_SAMPLE  = 4'd12;
   localparam logic [3:0] PH_RD_REC     = 4'd13;
   localparam logic [3:0] PH_APPLY      = 4'd14;

   // Sequence steps
   localparam logic [2:0] STEP_SKIP_A  = 3'd0;
   localparam logic [2:0] STEP_CONVERT = 3'd1;
   localparam logic [2:0] STEP_WAIT    = 3'd2;
   localparam logic [2:0] STEP_SKIP_B  = 3'd3;
   localparam logic [2:0] STEP_READPAD = 3'd4;
   localparam logic [2:0] STEP_RD_LO   = 3'd5;
   localparam logic [2:0] STEP_RD_HI   = 3'd6;

   localparam int CW = owtf_pkg::CNT_W;

   logic [3:0]                     phase_ff, phase_in;
   logic [CW-1:0]                  delay_ff, delay_in;
   logic [2:0]                     bit_ff, bit_in;
   logic [2:0]                     byte_ff, byte_in;
   logic [7:0]                     shift_ff, shift_in;
   logic [7:0]                     low_ff, low_in;
   logic [owtf_pkg::TEMP_W-1:0]    temp_ff, temp_in;
   logic [owtf_pkg::LEVEL_W-1:0]   level_ff, level_in;
   logic [owtf_pkg::DAC_W-1:0]     dac_ff, dac_in;

   logic [owtf_pkg::LEVEL_W-1:0]   calc_level;
   logic [owtf_pkg::DAC_W-1:0]     calc_dac;
   logic [CW-1:0]                  wait_len;
   logic [CW-1:0]                  cnt_inc;
   logic                           wait_hit;
   logic [2:0]                     step_sel;
   logic [3:0]                     step_phase;
   logic [7:0]                     step_shift;
   logic                           drive;
   logic                           done;

   owtf_level u_level (
      .temp  (temp_ff),
      .level (calc_level),
      .dac   (calc_dac)
   );

   // Wait length of the current phase
   always_comb begin
      case (phase_ff)
         PH_RST_PRE:    wait_len = CW'(cfg.reset_pre_ticks);
         PH_RST_LOW:    wait_len = CW'(cfg.reset_low_ticks);
         PH_PRES_DELAY: wait_len = CW'(cfg.presence_delay_ticks);
         PH_PRES_POST:  wait_len = CW'(cfg.presence_post_ticks);
         PH_WR_HOLD:    wait_len = CW'(cfg.write_hold_ticks);
         PH_WR_REC:     wait_len = CW'(cfg.write_recovery_ticks);
         PH_RD_REC:     wait_len = CW'(cfg.read_recovery_ticks);
         PH_CONV:       wait_len = cfg.conversion_ticks;
         default:       wait_len = '0;
      endcase
      cnt_inc  = delay_ff + CW'(1);
      wait_hit = (cnt_inc >= wait_len);
   end

   // Entry into the next sequence step
   always_comb begin
      step_sel   = (phase_ff == PH_PRES_POST) ? byte_ff : byte_ff + 3'd1;
      step_shift = shift_ff;
      unique case (step_sel) inside
         STEP_SKIP_A, STEP_SKIP_B: begin
            step_shift = owtf_pkg::CMD_SKIP_ROM;
            step_phase = PH_WR_LOW;
         end
         STEP_CONVERT: begin
            step_shift = owtf_pkg::CMD_CONVERT;
            step_phase = PH_WR_LOW;
         end
         STEP_READPAD: begin
            step_shift = owtf_pkg::CMD_READ_PAD;
            step_phase = PH_WR_LOW;
         end
         STEP_WAIT:  step_phase = PH_CONV;
         STEP_RD_LO, STEP_RD_HI: begin
            step_shift = 8'h00;
            step_phase = PH_RD_LOW;
         end
         default:    step_phase = PH_APPLY;
      endcase
   end

   // Phase machine for one tick
   always_comb begin
      phase_in = phase_ff;
      delay_in = delay_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      shift_in = shift_ff;
      low_in   = low_ff;
      temp_in  = temp_ff;
      level_in = level_ff;
      dac_in   = dac_ff;
      drive    = 1'b0;
      done     = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start_request) begin
               byte_in  = STEP_SKIP_A;
               delay_in = '0;
               phase_in = PH_RST_PRE;
            end
         end
         PH_RST_PRE: begin
            delay_in = wait_hit ? '0 : cnt_inc;
            if (wait_hit) phase_in = PH_RST_LOW;
         end
         PH_RST_LOW: begin
            drive    = 1'b1;
            delay_in = wait_hit ? '0 : cnt_inc;
            if (wait_hit) phase_in = PH_PRES_DELAY;
         end
         PH_PRES_DELAY: begin
            delay_in = wait_hit ? '0 : cnt_inc;
            if (wait_hit) phase_in = PH_PRES_LOW;
         end
         PH_PRES_LOW: begin
            if (!line_level) phase_in = PH_PRES_HIGH;
         end
         PH_PRES_HIGH: begin
            if (line_level) begin
               delay_in = '0;
               phase_in = PH_PRES_POST;
            end
         end
         PH_PRES_POST: begin
            delay_in = wait_hit ? '0 : cnt_inc;
            if (wait_hit) begin
               bit_in   = '0;
               shift_in = step_shift;
               phase_in = step_phase;
            end
         end
         PH_WR_LOW: begin
            drive    = 1'b1;
            delay_in = '0;
            phase_in = PH_WR_HOLD;
         end
         PH_WR_HOLD: begin
            drive    = ~shift_ff[0];
            delay_in = wait_hit ? '0 : cnt_inc;
            if (wait_hit) phase_in = PH_WR_REC;
         end
         PH_WR_REC: begin
            delay_in = wait_hit ? '0 : cnt_inc;
            if (wait_hit) begin
               shift_in = {1'b0, shift_ff[7:1]};
               bit_in   = bit_ff + 3'd1;
               if (bit_ff == 3'd7) begin
                  byte_in  = step_sel;
                  shift_in = step_shift;
                  phase_in = step_phase;
               end else begin
                  phase_in = PH_WR_LOW;
               end
            end
         end
         PH_CONV: begin
            delay_in = wait_hit ? '0 : cnt_inc;
            if (wait_hit) begin
               byte_in  = STEP_SKIP_B;
               phase_in = PH_RST_PRE;
            end
         end
         PH_RD_LOW: begin
            drive    = 1'b1;
            phase_in = PH_RD_SAMPLE;
         end
         PH_RD_SAMPLE: begin
            shift_in = {line_level, shift_ff[7:1]};
            delay_in = '0;
            phase_in = PH_RD_REC;
         end
         PH_RD_REC: begin
            delay_in = wait_hit ? '0 : cnt_inc;
            if (wait_hit) begin
               bit_in = bit_ff + 3'd1;
               if (bit_ff == 3'd7) begin
                  if (byte_ff == STEP_RD_LO) begin
                     low_in = shift_ff;
                  end else begin
                     temp_in = {shift_ff, low_ff};
                  end
                  byte_in  = step_sel;
                  shift_in = step_shift;
                  phase_in = step_phase;
               end else begin
                  phase_in = PH_RD_LOW;
               end
            end
         end
         PH_APPLY: begin
            level_in = calc_level;
            dac_in   = calc_dac;
            done     = 1'b1;
            byte_in  = STEP_SKIP_A;
            delay_in = '0;
            phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // State advances once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         delay_ff <= '0;
         bit_ff   <= '0;
         byte_ff  <= '0;
         shift_ff <= '0;
         low_ff   <= '0;
         temp_ff  <= '0;
         level_ff <= '0;
         dac_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         delay_ff <= delay_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         low_ff   <= low_in;
         temp_ff  <= temp_in;
         level_ff <= level_in;
         dac_ff   <= dac_in;
      end
   end

   assign res.done_res        = done;
   assign res.busy_res        = (phase_ff != PH_IDLE);
   assign res.temperature_raw = temp_in;
   assign res.fan_level       = level_in;
   assign res.dac_code        = dac_in;
   assign res.line_drive_low  = drive;

endmodule

@@ rtl/owtf_checker.sv @@
// Port-level checks for the controller, bound to the top level.
`timescale 1ns / 1ps
module owtf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // Result held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // Empty output register never blocks a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty output register");

   // Completion and bus drive only during a measurement
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[29] || rsp_tdata[0]) |-> rsp_tdata[28])
      else $error("done or bus drive outside a measurement");

   // Level range and DAC code agree
   a_level_dac: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11:9] <= 3'(owtf_pkg::MAX_LEVEL)) &&
                     (rsp_tdata[8:1] == 8'(rsp_tdata[11:9] * 8'(owtf_pkg::LEVEL_STEP_CODE))))
      else $error("fan level and DAC code disagree");

endmodule

bind onewire_temp_fan_level_controller owtf_checker u_owtf_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking bench for the one-wire temperature master with fan level output.
`timescale 1ns / 1ps
module tb_top;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 10;

   // Sequence steps, walked by the step index
   localparam logic [2:0] STEP_SKIP_ROM_A = 3'd0;
   localparam logic [2:0] STEP_CONVERT    = 3'd1;
   localparam logic [2:0] STEP_CONV_WAIT  = 3'd2;
   localparam logic [2:0] STEP_SKIP_ROM_B = 3'd3;
   localparam logic [2:0] STEP_READ_CMD   = 3'd4;
   localparam logic [2:0] STEP_READ_LOW   = 3'd5;
   localparam logic [2:0] STEP_READ_HIGH  = 3'd6;

   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_RST_PRE, SEQ_RST_LOW, SEQ_PRES_DELAY, SEQ_PRES_LOW,
      SEQ_PRES_HIGH, SEQ_PRES_POST, SEQ_WR_LOW, SEQ_WR_HOLD, SEQ_WR_REC,
      SEQ_CONV, SEQ_RD_LOW, SEQ_RD_SAMPLE, SEQ_RD_REC, SEQ_APPLY
   } seq_phase_type;

   typedef struct packed {
      seq_phase_type phase;
      logic [23:0]   delay_count;
      logic [2:0]    bit_index;
      logic [2:0]    step;
      logic [7:0]    shift_byte;
      logic [7:0]    low_byte;
      logic [15:0]   temp_reg;
      logic [2:0]    level_reg;
      logic [7:0]    dac_reg;
   } seq_state_type;

   typedef struct packed {
      seq_state_type     nxt;
      owtf_pkg::res_type res;
   } seq_tick_type;

   typedef struct packed {
      logic start_request;
      logic line_level;
   } bus_tick_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata  = '0;   // [0] line_level, [1] start_request
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   // [0] line_drive_low, [8:1] dac_code, [11:9] fan_level,
   // [27:12] temperature_raw, [28] busy_res, [29] done_res
   logic [31:0]                   rsp_tdata;
   logic                          csr_we     = 1'b0;
   logic [owtf_pkg::CSR_AW-1:0]   csr_addr   = '0;
   logic [owtf_pkg::CSR_DW-1:0]   csr_wdata  = '0;

   owtf_pkg::cfg_type             timing_cfg;
   logic [owtf_pkg::CSR_DW-1:0]   timing_plan [8];
   seq_state_type                 model_state;
   seq_state_type                 gen_state;
   bus_tick_type                  bus_ticks_pending [$];
   owtf_pkg::res_type             bus_results_due [$];
   logic                          req_taken = 1'b0;
   int                            send_idle_pct;
   int                            recv_idle_pct;
   int                            errors          = 0;
   int                            results_checked = 0;
   int                            levels_applied  = 0;
   int                            ticks_queued    = 0;
   int                            settings_used   = 0;
   int                            stalled_cycles  = 0;

   always #4 clock = ~clock;

   onewire_temp_fan_level_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // One tick of a wait: true once the count reaches the limit (zero acts as one)
   function automatic logic wait_elapsed(input logic [23:0] count, input logic [23:0] limit,
                                         output logic [23:0] count_next);
      count_next = count + 24'd1;
      if (count_next >= limit) begin
         count_next = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Load the command or wait that belongs to the current step
   function automatic seq_state_type enter_step(input seq_state_type s);
      s.bit_index   = '0;
      s.delay_count = '0;
      case (s.step)
         STEP_SKIP_ROM_A, STEP_SKIP_ROM_B: begin
            s.shift_byte = owtf_pkg::CMD_SKIP_ROM;
            s.phase      = SEQ_WR_LOW;
         end
         STEP_CONVERT: begin
            s.shift_byte = owtf_pkg::CMD_CONVERT;
            s.phase      = SEQ_WR_LOW;
         end
         STEP_READ_CMD: begin
            s.shift_byte = owtf_pkg::CMD_READ_PAD;
            s.phase      = SEQ_WR_LOW;
         end
         STEP_CONV_WAIT: s.phase = SEQ_CONV;
         STEP_READ_LOW, STEP_READ_HIGH: begin
            s.shift_byte = '0;
            s.phase      = SEQ_RD_LOW;
         end
         default: s.phase = SEQ_APPLY;
      endcase
      return s;
   endfunction

   // Bus sequencer: next state and the result of one accepted tick
   function automatic seq_tick_type sequencer_tick(input seq_state_type cur,
                                                   input owtf_pkg::cfg_type c,
                                                   input logic line_bit, input logic start_bit);
      seq_state_type s;
      seq_tick_type  t;
      logic          drive;
      logic          done_flag;
      logic          over;
      logic [23:0]   lim;
      logic [23:0]   cnt;
      int            raw_val;
      int            lvl;
      int            code;
      s         = cur;
      drive     = 1'b0;
      done_flag = 1'b0;
      case (cur.phase)
         SEQ_RST_PRE:    lim = {8'd0, c.reset_pre_ticks};
         SEQ_RST_LOW:    lim = {8'd0, c.reset_low_ticks};
         SEQ_PRES_DELAY: lim = {8'd0, c.presence_delay_ticks};
         SEQ_PRES_POST:  lim = {8'd0, c.presence_post_ticks};
         SEQ_WR_HOLD:    lim = {8'd0, c.write_hold_ticks};
         SEQ_WR_REC:     lim = {8'd0, c.write_recovery_ticks};
         SEQ_RD_REC:     lim = {8'd0, c.read_recovery_ticks};
         SEQ_CONV:       lim = c.conversion_ticks;
         default:        lim = '0;
      endcase
      over = wait_elapsed(cur.delay_count, lim, cnt);

      case (cur.phase)
         SEQ_IDLE: if (start_bit) begin
            s.step        = STEP_SKIP_ROM_A;
            s.delay_count = '0;
            s.phase       = SEQ_RST_PRE;
         end
         SEQ_RST_PRE: begin
            s.delay_count = cnt;
            if (over) s.phase = SEQ_RST_LOW;
         end
         SEQ_RST_LOW: begin
            drive         = 1'b1;
            s.delay_count = cnt;
            if (over) s.phase = SEQ_PRES_DELAY;
         end
         SEQ_PRES_DELAY: begin
            s.delay_count = cnt;
            if (over) s.phase = SEQ_PRES_LOW;
         end
         // presence pulse: wait for low, then high, no timeout
         SEQ_PRES_LOW: if (!line_bit) s.phase = SEQ_PRES_HIGH;
         SEQ_PRES_HIGH: if (line_bit) begin
            s.delay_count = '0;
            s.phase       = SEQ_PRES_POST;
         end
         SEQ_PRES_POST: begin
            s.delay_count = cnt;
            if (over) s = enter_step(s);
         end
         SEQ_WR_LOW: begin
            drive         = 1'b1;
            s.delay_count = '0;
            s.phase       = SEQ_WR_HOLD;
         end
         SEQ_WR_HOLD: begin
            drive         = ~cur.shift_byte[0];
            s.delay_count = cnt;
            if (over) s.phase = SEQ_WR_REC;
         end
         SEQ_WR_REC: begin
            s.delay_count = cnt;
            if (over) begin
               s.shift_byte = cur.shift_byte >> 1;
               s.bit_index  = cur.bit_index + 3'd1;
               if (s.bit_index == 3'd0) begin
                  s.step = cur.step + 3'd1;
                  s      = enter_step(s);
               end else begin
                  s.phase = SEQ_WR_LOW;
               end
            end
         end
         SEQ_CONV: begin
            s.delay_count = cnt;
            if (over) begin
               s.step        = STEP_SKIP_ROM_B;
               s.delay_count = '0;
               s.phase       = SEQ_RST_PRE;
            end
         end
         SEQ_RD_LOW: begin
            drive   = 1'b1;
            s.phase = SEQ_RD_SAMPLE;
         end
         SEQ_RD_SAMPLE: begin
            s.shift_byte  = {line_bit, cur.shift_byte[7:1]};
            s.delay_count = '0;
            s.phase       = SEQ_RD_REC;
         end
         SEQ_RD_REC: begin
            s.delay_count = cnt;
            if (over) begin
               s.bit_index = cur.bit_index + 3'd1;
               if (s.bit_index == 3'd0) begin
                  if (cur.step == STEP_READ_LOW) s.low_byte = cur.shift_byte;
                  else s.temp_reg = {cur.shift_byte, cur.low_byte};
                  s.step = cur.step + 3'd1;
                  s      = enter_step(s);
               end else begin
                  s.phase = SEQ_RD_LOW;
               end
            end
         end
         SEQ_APPLY: begin
            // whole degrees above the threshold, saturated
            raw_val = int'($signed(cur.temp_reg));
            lvl     = 0;
            if (raw_val > owtf_pkg::THRESHOLD_RAW) begin
               lvl = (raw_val - owtf_pkg::THRESHOLD_RAW) >>> 4;
               if (lvl > owtf_pkg::MAX_LEVEL) lvl = owtf_pkg::MAX_LEVEL;
            end
            code = lvl * owtf_pkg::LEVEL_STEP_CODE;
            if (code > 255) code = 255;
            s.level_reg   = lvl[2:0];
            s.dac_reg     = code[7:0];
            done_flag     = 1'b1;
            s.step        = STEP_SKIP_ROM_A;
            s.delay_count = '0;
            s.phase       = SEQ_IDLE;
         end
         default: s.phase = SEQ_IDLE;
      endcase

      t.nxt                 = s;
      t.res.line_drive_low  = drive;
      t.res.dac_code        = s.dac_reg;
      t.res.fan_level       = s.level_reg;
      t.res.temperature_raw = s.temp_reg;
      t.res.busy_res        = (cur.phase != SEQ_IDLE);
      t.res.done_res        = done_flag;
      return t;
   endfunction

   task automatic compare_field(input string field, input logic [15:0] want_v,
                                input logic [15:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
         errors++;
      end
   endtask

   // Request driver: holds a presented tick until taken, idles at random
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (bus_ticks_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {6'd0, bus_ticks_pending[0]};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Monitor: check results, predict accepted ticks, watch for a hang
   always @(posedge clock) begin : bus_monitor
      owtf_pkg::res_type got;
      owtf_pkg::res_type want;
      seq_tick_type      t;
      if (reset) begin
         req_taken      = 1'b0;
         stalled_cycles = 0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[29:0];
            if (bus_results_due.size() == 0) begin
               $error("result 0x%08h with no request outstanding", rsp_tdata);
               errors++;
            end else begin
               want = bus_results_due.pop_front();
               compare_field("line_drive_low", 16'(want.line_drive_low),
                             16'(got.line_drive_low));
               compare_field("dac_code", 16'(want.dac_code), 16'(got.dac_code));
               compare_field("fan_level", 16'(want.fan_level), 16'(got.fan_level));
               compare_field("temperature_raw", want.temperature_raw, got.temperature_raw);
               compare_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
               compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
               results_checked++;
               if (got.done_res) levels_applied++;
            end
         end
         if (req_taken) begin
            t           = sequencer_tick(model_state, timing_cfg, req_tdata[0], req_tdata[1]);
            model_state = t.nxt;
            bus_results_due.push_back(t.res);
            void'(bus_ticks_pending.pop_front());
         end
         if (req_taken || (rsp_tvalid && rsp_tready)) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
               $display("SCOREBOARD MISMATCH");
               $finish;
            end
         end
      end
   end

   // Queue one tick and advance the stimulus-side copy of the sequencer
   task automatic push_tick(input logic line_bit, input logic start_bit);
      seq_tick_type t;
      bus_tick_type item;
      t                  = sequencer_tick(gen_state, timing_cfg, line_bit, start_bit);
      gen_state          = t.nxt;
      item.line_level    = line_bit;
      item.start_request = start_bit;
      bus_ticks_pending.push_back(item);
      ticks_queued++;
   endtask

   task automatic idle_ticks(input int n);
      repeat (n) push_tick(1'($urandom_range(0, 1)), 1'b0);
   endtask

   // Full measurement: a responding sensor that returns raw on the read slots
   task automatic run_measurement(input logic [15:0] raw, input int lag_hi, input int lag_lo,
                                  input bit noisy);
      int         hi_left;
      int         lo_left;
      logic       line_bit;
      logic [3:0] bit_pos;
      hi_left = lag_hi;
      lo_left = lag_lo;
      push_tick(1'($urandom_range(0, 1)), 1'b1);
      while (gen_state.phase != SEQ_IDLE) begin
         line_bit = 1'($urandom_range(0, 1));
         case (gen_state.phase)
            SEQ_PRES_DELAY: begin
               hi_left = lag_hi;
               lo_left = lag_lo;
            end
            SEQ_PRES_LOW: if (hi_left > 0) begin
               line_bit = 1'b1;
               hi_left--;
            end else begin
               line_bit = 1'b0;
            end
            SEQ_PRES_HIGH: if (lo_left > 0) begin
               line_bit = 1'b0;
               lo_left--;
            end else begin
               line_bit = 1'b1;
            end
            SEQ_RD_SAMPLE: begin
               bit_pos  = {gen_state.step == STEP_READ_HIGH, gen_state.bit_index};
               line_bit = raw[bit_pos];
            end
            default: ;
         endcase
         // starts while busy must be ignored
         push_tick(line_bit, noisy && ($urandom_range(0, 7) == 0));
      end
   endtask

   function automatic logic [15:0] random_raw();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'd400 + 16'($urandom_range(0, 160));
         2: case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         default: return 16'($urandom_range(0, 1000));
      endcase
   endfunction

   // Mostly a prompt presence pulse, now and then a slow one
   function automatic int presence_lag();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   task automatic random_phase(input int min_ticks, input int min_meas);
      int first_tick;
      int meas;
      first_tick = ticks_queued;
      meas       = 0;
      while (ticks_queued - first_tick < min_ticks || meas < min_meas) begin
         if ($urandom_range(0, 99) < 15) begin
            idle_ticks($urandom_range(1, 6));
         end else begin
            run_measurement(random_raw(), presence_lag(), presence_lag(),
                            $urandom_range(0, 9) < 3);
            meas++;
         end
      end
   endtask

   // Register write while the sequencer is idle; shadow copy masked to width
   task automatic csr_write(input logic [owtf_pkg::CSR_AW-1:0] idx,
                            input logic [owtf_pkg::CSR_DW-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         owtf_pkg::CSR_RESET_PRE:  timing_cfg.reset_pre_ticks      = value[15:0];
         owtf_pkg::CSR_RESET_LOW:  timing_cfg.reset_low_ticks      = value[15:0];
         owtf_pkg::CSR_PRES_DELAY: timing_cfg.presence_delay_ticks = value[15:0];
         owtf_pkg::CSR_PRES_POST:  timing_cfg.presence_post_ticks  = value[15:0];
         owtf_pkg::CSR_WRITE_HOLD: timing_cfg.write_hold_ticks     = value[15:0];
         owtf_pkg::CSR_WRITE_REC:  timing_cfg.write_recovery_ticks = value[15:0];
         owtf_pkg::CSR_READ_REC:   timing_cfg.read_recovery_ticks  = value[15:0];
         owtf_pkg::CSR_CONVERSION: timing_cfg.conversion_ticks     = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_timing_plan();
      for (int i = 0; i < 8; i++) csr_write(i[owtf_pkg::CSR_AW-1:0], timing_plan[i]);
      settings_used++;
   endtask

   task automatic plan_random_small();
      timing_plan[owtf_pkg::CSR_RESET_PRE]  = 24'($urandom_range(0, 3));
      timing_plan[owtf_pkg::CSR_RESET_LOW]  = 24'($urandom_range(1, 4));
      timing_plan[owtf_pkg::CSR_PRES_DELAY] = 24'($urandom_range(0, 3));
      timing_plan[owtf_pkg::CSR_PRES_POST]  = 24'($urandom_range(0, 3));
      timing_plan[owtf_pkg::CSR_WRITE_HOLD] = 24'($urandom_range(1, 3));
      timing_plan[owtf_pkg::CSR_WRITE_REC]  = 24'($urandom_range(0, 2));
      timing_plan[owtf_pkg::CSR_READ_REC]   = 24'($urandom_range(0, 2));
      timing_plan[owtf_pkg::CSR_CONVERSION] = 24'($urandom_range(1, 30));
   endtask

   // Phase boundary: everything sent and every result back
   task automatic wait_drained();
      while (bus_ticks_pending.size() != 0 || bus_results_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Level step edge, saturation, sign and largest positive
   logic [15:0] corner_temps [5] = '{
      16'd447, 16'd448, 16'd528, 16'h8000, 16'h7FFF
   };

   initial begin
      timing_cfg    = '{16'd8, 16'd80, 16'd14, 16'd20, 16'd10, 16'd5, 16'd8, 24'd150000};
      model_state   = '0;   // idle, all registers clear
      gen_state     = '0;
      send_idle_pct = 29;
      recv_idle_pct = 51;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Shortest waits everywhere: corner temperatures
      timing_plan = '{24'd0, 24'd1, 24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd1};
      apply_timing_plan();
      for (int i = 0; i < 5; i++) begin
         run_measurement(corner_temps[i], (i == 3) ? 40 : i % 3, i % 4, 1'(i % 2));
         idle_ticks(2);
      end
      wait_drained();

      send_idle_pct = 51;
      recv_idle_pct = 29;
      // Junk above bit 15 must be dropped by the 16-bit registers
      timing_plan = '{24'hA50002, 24'h5A0001, 24'hFF0003, 24'h010000,
                      24'hC30002, 24'h3C0001, 24'h800003, 24'h00000A};
      apply_timing_plan();
      random_phase(150, 1);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      plan_random_small();
      apply_timing_plan();
      random_phase(150, 1);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Covered %0d bus ticks, %0d fan level updates, %0d timing settings.",
               ticks_queued, levels_applied, settings_used);
      $display("%0d results compared, %0d field errors.", results_checked, errors);
      if (errors == 0 && bus_results_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ onewire_temp_fan_level_controller.f @@
rtl/owtf_pkg.sv
rtl/owtf_csr.sv
rtl/owtf_level.sv
rtl/owtf_seq.sv
rtl/onewire_temp_fan_level_controller.sv
rtl/owtf_checker.sv
tb/tb_top.sv
